// ----- design/nrp_pkg.sv -----
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and constants for the negacyclic rotate polynomial block:
// request and response field types and request command codes.
// ----------------------------------------------------------------------------
package nrp_pkg;

   // field widths fixed by the request and response formats
   localparam int INDEX_W = 10;
   localparam int COEF_W  = 32;
   localparam int SHIFT_W = 11;

   typedef logic                      cmd_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic [SHIFT_W-1:0]        shift_type;

   // request command codes
   localparam cmd_type CMD_LOAD = 1'b0;
   localparam cmd_type CMD_READ = 1'b1;

endpackage

// ----- design/nrp_if.sv -----
// ----------------------------------------------------------------------------
// nrp_if
// Valid/ready channels of the negacyclic rotate polynomial block: the
// request channel (loads and reads) and the response channel.
// ----------------------------------------------------------------------------
interface nrp_req_if;
   import nrp_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   cmd;
   index_type index;
   coef_type  coef_in;
   shift_type shift;
   logic      minus_one;

   modport source (output valid, cmd, index, coef_in, shift, minus_one, input ready);
   modport sink   (input valid, cmd, index, coef_in, shift, minus_one, output ready);
endinterface

interface nrp_rsp_if;
   import nrp_pkg::*;

   logic      valid;
   logic      ready;
   index_type out_index;
   coef_type  out_value;

   modport source (output valid, out_index, out_value, input ready);
   modport sink   (input valid, out_index, out_value, output ready);
endinterface

// ----- design/negacyclic_rotate_polynomial.sv -----
// ----------------------------------------------------------------------------
// negacyclic_rotate_polynomial
// Stores one polynomial of POLY_DEGREE coefficients and returns coefficients
// of the stored polynomial times X^p (or X^p - 1) modulo X^N + 1.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the response channel is not stalled;
// loads and out-of-range reads give no response
// pipeline: input register, shift reduction, store read, result register
// reset clears all pipeline valid flags; store contents undefined until loaded
module negacyclic_rotate_polynomial #(
   parameter int POLY_DEGREE = 1024
) (
   input logic     clock,
   input logic     reset,
   nrp_req_if.sink   req_bus,
   nrp_rsp_if.source rsp_bus
);
   import nrp_pkg::*;

   localparam int AW   = $clog2(POLY_DEGREE);
   localparam int D2   = 2 * POLY_DEGREE;
   localparam int L2   = $clog2(D2);
   localparam int SH   = SHIFT_W + L2;
   localparam int RCP  = ((1 << SH) + D2 - 1) / D2;
   localparam int RCPW = $clog2(RCP + 1);
   localparam int PW   = SHIFT_W + RCPW;
   localparam int TW   = ((AW > SHIFT_W) ? AW : SHIFT_W) + 2;

   // handshake chain
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   // stage payloads
   cmd_type          s1_cmd_ff;
   index_type        s1_index_ff;
   logic [COEF_W-1:0] s1_coef_ff;
   shift_type        s1_shift_ff;
   logic             s1_minus_ff;

   cmd_type          s2_cmd_ff;
   index_type        s2_index_ff;
   logic [COEF_W-1:0] s2_coef_ff;
   shift_type        s2_shift_ff;
   logic             s2_minus_ff;
   logic [SHIFT_W-1:0] s2_quo_ff, s2_quo_in;

   index_type        s3_index_ff;
   logic             s3_neg_ff, s3_neg_in;
   logic             s3_minus_ff;

   index_type        rsp_index_ff;
   logic [COEF_W-1:0] rsp_value_ff, rsp_value_in;

   logic             req_in_range;
   logic [PW-1:0]    quo_prod;
   logic [TW-1:0]    wrap_pos;
   logic [TW-1:0]    addr_sel;
   logic             wr_en, rd_en;
   logic [COEF_W-1:0] rd_term, rd_self;
   logic [COEF_W-1:0] signed_term;

   // ready chain, each stage frees when empty or moving on
   assign out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   // indexes at or past the degree are dropped at the input
   assign req_in_range = TW'(req_bus.index) < TW'(POLY_DEGREE);
   assign s1_valid_in  = req_bus.valid && req_in_range;

   // stage 1 input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_bus.valid) begin
         s1_cmd_ff   <= req_bus.cmd;
         s1_index_ff <= req_bus.index;
         s1_coef_ff  <= req_bus.coef_in;
         s1_shift_ff <= req_bus.shift;
         s1_minus_ff <= req_bus.minus_one;
      end
   end

   // quotient of shift by 2N through reciprocal multiply
   assign quo_prod    = PW'(s1_shift_ff) * PW'(RCP);
   assign s2_quo_in   = SHIFT_W'(quo_prod >> SH);
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_index_ff <= s1_index_ff;
         s2_coef_ff  <= s1_coef_ff;
         s2_shift_ff <= s1_shift_ff;
         s2_minus_ff <= s1_minus_ff;
         s2_quo_ff   <= s2_quo_in;
      end
   end

   // index minus reduced shift, offset by 2N so it stays non-negative
   assign wrap_pos = TW'(s2_index_ff) + TW'(s2_quo_ff) * TW'(D2) + TW'(D2)
                   - TW'(s2_shift_ff);

   // pick the source slot and the sign of the rotated term
   always_comb begin
      if (wrap_pos >= TW'(D2)) begin
         addr_sel  = wrap_pos - TW'(D2);
         s3_neg_in = 1'b0;
      end else if (wrap_pos >= TW'(POLY_DEGREE)) begin
         addr_sel  = wrap_pos - TW'(POLY_DEGREE);
         s3_neg_in = 1'b1;
      end else begin
         addr_sel  = wrap_pos;
         s3_neg_in = 1'b0;
      end
   end

   // loads write and leave the pipeline here, reads fetch both operands
   assign wr_en       = s2_valid_ff && (s2_cmd_ff == CMD_LOAD) && s3_ready;
   assign rd_en       = s2_valid_ff && (s2_cmd_ff == CMD_READ) && s3_ready;
   assign s3_valid_in = s2_valid_ff && (s2_cmd_ff == CMD_READ);

   nrp_coef_store #(
      .DEPTH  (POLY_DEGREE),
      .ADDR_W (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(s2_index_ff)),
      .wr_data   (s2_coef_ff),
      .rd_en     (rd_en),
      .rd_addr_a (AW'(addr_sel)),
      .rd_addr_b (AW'(s2_index_ff)),
      .rd_data_a (rd_term),
      .rd_data_b (rd_self)
   );

   // stage 3 holds read operands alongside the store output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s3_index_ff <= s2_index_ff;
         s3_neg_ff   <= s3_neg_in;
         s3_minus_ff <= s2_minus_ff;
      end
   end

   // signed term, minus the own coefficient for the X^p - 1 form
   assign signed_term  = s3_neg_ff ? (COEF_W'(0) - rd_term) : rd_term;
   assign rsp_value_in = s3_minus_ff ? (signed_term - rd_self) : signed_term;
   assign rsp_valid_in = s3_valid_ff;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         rsp_index_ff <= s3_index_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_value = coef_type'(rsp_value_ff);

endmodule

// ----- design/nrp_coef_store.sv -----
// ----------------------------------------------------------------------------
// nrp_coef_store
// Coefficient memory: one write port and two read ports with registered
// read data, read data held while the read enable is low.
// ----------------------------------------------------------------------------
module nrp_coef_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [nrp_pkg::COEF_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr_a,
   input  logic [ADDR_W-1:0]         rd_addr_b,
   output logic [nrp_pkg::COEF_W-1:0] rd_data_a,
   output logic [nrp_pkg::COEF_W-1:0] rd_data_b
);
   import nrp_pkg::*;

   logic [COEF_W-1:0] store_ff [DEPTH];
   logic [COEF_W-1:0] rd_a_ff;
   logic [COEF_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // two read ports, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
